[hw/rtl/hash_sparse_row_accumulator_top_assert.svh]
// Assertion macros for the hash sparse row accumulator.
// Used by the back-end module; no other dependencies.
`ifndef HASH_SPARSE_ROW_ACCUMULATOR_TOP_ASSERT_SVH
`define HASH_SPARSE_ROW_ACCUMULATOR_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define HSRA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("hsra assertion failed");

// Next-cycle implication checked outside reset.
`define HSRA_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("hsra assertion failed");

`endif

[hw/rtl/hsra_pkg.sv]
// Package for the hash sparse row accumulator: sizes, codes and payload types.
// No dependencies.
package hsra_pkg;

  localparam int PrimarySlots = 128;
  localparam int OverflowSlots = 1024;
  localparam int KeyBits = 24;
  localparam int PIdxW = $clog2(PrimarySlots);
  localparam int OIdxW = $clog2(OverflowSlots);
  localparam int TotalSlots = PrimarySlots + OverflowSlots;
  localparam int CurW = $clog2(TotalSlots + 1);
  localparam int QDepth = 2;
  // Length of the pass that clears both tables, one entry of each per cycle.
  localparam int WipeSlots = (OverflowSlots > PrimarySlots) ? OverflowSlots : PrimarySlots;

  typedef enum logic [2:0] {
    KIND_NEW = 3'd0,
    KIND_ACC = 3'd1,
    KIND_LOST = 3'd2,
    KIND_DRAIN = 3'd3,
    KIND_END = 3'd4
  } kind_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [0:0] CFG_OVF_SIZE = 1'b0;
  localparam logic [0:0] CFG_SKIP = 1'b1;

  typedef struct packed {
    logic command;
    logic [23:0] column;
    logic signed [31:0] b_value;
    logic signed [31:0] a_multiplier;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [10:0] slot;
    logic [23:0] out_column;
    logic signed [31:0] out_value;
    logic [15:0] insert_count;
    logic row_failed;
    logic last;
  } out_item_t;

  // Classified work handed from front to back.
  typedef struct packed {
    logic command;
    logic [KeyBits-1:0] key;
    logic signed [31:0] prod;
  } work_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRD,
    ST_PCHK,
    ST_ORD,
    ST_OCHK,
    ST_PWR,
    ST_OWR,
    ST_DSCAN,
    ST_DCHK,
    ST_CLR,
    ST_WIPE,
    ST_EMIT
  } st_t;

endpackage

[hw/rtl/hsra_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hsra_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/hsra_front.sv]
// Front end: accepts items, forms the saturated Q16.16 product, and queues work.
// Depends on hsra_pkg.
module hsra_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsra_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_ready,
  output hsra_pkg::work_t   q_data
);
  // Multiply stage registers.
  logic               m_v_r;
  logic               m_cmd_r;
  logic [hsra_pkg::KeyBits-1:0] m_key_r;
  logic signed [63:0] m_p_r;
  logic signed [31:0] prod;
  logic signed [63:0] q;
  hsra_pkg::work_t    fifo_r [hsra_pkg::QDepth];
  logic [0:0]         wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic               push, pop;

  // Accept only when the multiply stage and queue have room.
  assign in_ready = !m_v_r && (cnt_r < 2'(hsra_pkg::QDepth));
  assign push = m_v_r;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else begin
      m_v_r <= in_valid && in_ready;
    end
    m_cmd_r <= in_data.command;
    m_key_r <= in_data.column[hsra_pkg::KeyBits-1:0];
    m_p_r <= 64'(in_data.b_value) * 64'(in_data.a_multiplier);
  end

  // Arithmetic shift floors toward minus infinity; then saturate.
  always_comb begin
    q = m_p_r >>> 16;
    if (q > 64'sd2147483647) prod = 32'sh7fffffff;
    else if (q < -64'sd2147483648) prod = 32'sh80000000;
    else prod = q[31:0];
  end

  // Small work queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) fifo_r[wp_r] <= '{command: m_cmd_r, key: m_key_r, prod: prod};
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_data = fifo_r[rp_r];
endmodule

[hw/rtl/hsra_back.sv]
// Back end: probes the hash tables, accumulates, drains and clears.
// Depends on hsra_pkg, hsra_ram and the assertion macro header.
`include "hash_sparse_row_accumulator_top_assert.svh"
module hsra_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  hsra_pkg::work_t   q_data,
  input  logic [10:0]       ovf_size,
  input  logic              skip_cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output hsra_pkg::out_item_t out_data
);
  localparam int PW = hsra_pkg::PIdxW;
  localparam int OW = hsra_pkg::OIdxW;
  localparam int KW = hsra_pkg::KeyBits;
  // Table entry: occupied mark, key, value.
  localparam int EW = KW + 33;

  localparam logic [2:0] KIND_NEW_F = 3'(hsra_pkg::KIND_NEW);
  localparam logic [2:0] KIND_ACC_F = 3'(hsra_pkg::KIND_ACC);
  localparam logic [2:0] KIND_LOST_F = 3'(hsra_pkg::KIND_LOST);
  localparam logic [2:0] KIND_DRAIN_F = 3'(hsra_pkg::KIND_DRAIN);
  localparam logic [2:0] KIND_END_F = 3'(hsra_pkg::KIND_END);

  hsra_pkg::st_t st_r, st_nxt;
  hsra_pkg::work_t w_r;
  logic [PW-1:0] pidx_r;
  logic [OW-1:0] oidx_r;
  logic [hsra_pkg::CurW-1:0] pcnt_r, ocnt_r;
  logic [hsra_pkg::CurW-1:0] cur_r;
  logic [hsra_pkg::CurW-1:0] clr_r;
  logic wipe_end_r;
  logic [OW:0] osz_r;
  logic [OW-1:0] omask_r;
  logic [15:0] cnt_r;
  logic failed_r;
  logic hit_new_r;
  hsra_pkg::out_item_t rs_r;
  hsra_pkg::out_item_t res_r;
  logic ov_r;

  logic [EW-1:0] prd, ord;
  logic pocc, oocc;
  logic [KW-1:0] pk, ok;
  logic signed [31:0] pv, ov;
  logic pwe, owe;
  logic [PW-1:0] praddr, pwaddr;
  logic [OW-1:0] oraddr, owaddr;
  logic [EW-1:0] wdata;
  logic signed [32:0] sum;
  logic signed [31:0] sumsat;
  logic [15:0] cnt_inc;
  logic skip;
  logic cur_p;
  logic [PW-1:0] cur_pi;
  logic [OW-1:0] cur_oi;
  logic cur_occ;
  logic wiping;
  logic wipe_last;
  logic load_out;

  assign pocc = prd[EW-1];
  assign pk = prd[KW+31:32];
  assign pv = prd[31:0];
  assign oocc = ord[EW-1];
  assign ok = ord[KW+31:32];
  assign ov = ord[31:0];

  hsra_ram #(.Width(EW), .Depth(hsra_pkg::PrimarySlots)) u_pram (
    .clk(clk), .we(pwe), .waddr(pwaddr), .wdata(wdata), .raddr(praddr), .rdata(prd));
  hsra_ram #(.Width(EW), .Depth(hsra_pkg::OverflowSlots)) u_oram (
    .clk(clk), .we(owe), .waddr(owaddr), .wdata(wdata), .raddr(oraddr), .rdata(ord));

  // Drain cursor decode; the occupied mark comes from the entry read in the state before, ST_DSCAN.
  assign cur_p = cur_r < hsra_pkg::CurW'(hsra_pkg::PrimarySlots);
  assign cur_pi = cur_r[PW-1:0];
  assign cur_oi = OW'(cur_r - hsra_pkg::CurW'(hsra_pkg::PrimarySlots));
  assign cur_occ = cur_p ? pocc : oocc;

  assign wipe_last = (clr_r == hsra_pkg::CurW'(hsra_pkg::WipeSlots - 1));
  assign skip = skip_cfg && failed_r;
  assign cnt_inc = (cnt_r != 16'hffff) ? cnt_r + 16'd1 : cnt_r;

  // Saturated sum of the stored value (zero for a new key) and the product; the stored value alone when skip is set.
  always_comb begin
    logic signed [31:0] base;
    base = hit_new_r ? 32'sd0 : (st_r == hsra_pkg::ST_PWR ? pv : ov);
    sum = 33'(base) + 33'(w_r.prod);
    if (skip) sumsat = base;
    else if (sum > 33'sd2147483647) sumsat = 32'sh7fffffff;
    else if (sum < -33'sd2147483648) sumsat = 32'sh80000000;
    else sumsat = sum[31:0];
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      hsra_pkg::ST_IDLE: if (q_valid) begin
        st_nxt = (q_data.command == hsra_pkg::CMD_DRAIN) ? hsra_pkg::ST_DSCAN
                                                         : hsra_pkg::ST_PRD;
      end
      hsra_pkg::ST_PRD: st_nxt = hsra_pkg::ST_PCHK;
      hsra_pkg::ST_PCHK: begin
        if (!pocc || pk == w_r.key) st_nxt = hsra_pkg::ST_PWR;
        else if (pcnt_r == hsra_pkg::CurW'(hsra_pkg::PrimarySlots - 1)) begin
          st_nxt = (osz_r == '0) ? hsra_pkg::ST_EMIT : hsra_pkg::ST_ORD;
        end else st_nxt = hsra_pkg::ST_PRD;
      end
      hsra_pkg::ST_ORD: st_nxt = hsra_pkg::ST_OCHK;
      hsra_pkg::ST_OCHK: begin
        if (!oocc || ok == w_r.key) st_nxt = hsra_pkg::ST_OWR;
        else if (ocnt_r == hsra_pkg::CurW'(osz_r - 1'b1)) st_nxt = hsra_pkg::ST_EMIT;
        else st_nxt = hsra_pkg::ST_ORD;
      end
      hsra_pkg::ST_PWR, hsra_pkg::ST_OWR: st_nxt = hsra_pkg::ST_EMIT;
      hsra_pkg::ST_DSCAN: begin
        if (cur_r == hsra_pkg::CurW'(hsra_pkg::TotalSlots)) st_nxt = hsra_pkg::ST_CLR;
        else st_nxt = hsra_pkg::ST_DCHK;
      end
      hsra_pkg::ST_DCHK: st_nxt = cur_occ ? hsra_pkg::ST_EMIT : hsra_pkg::ST_DSCAN;
      hsra_pkg::ST_CLR: st_nxt = hsra_pkg::ST_WIPE;
      hsra_pkg::ST_WIPE: if (wipe_last) begin
        st_nxt = wipe_end_r ? hsra_pkg::ST_EMIT : hsra_pkg::ST_IDLE;
      end
      hsra_pkg::ST_EMIT: if (load_out) st_nxt = hsra_pkg::ST_IDLE;
      default: st_nxt = hsra_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine: RAM ports, queue handshake and result load.
  always_comb begin
    wiping = (st_r == hsra_pkg::ST_WIPE);
    q_ready = (st_r == hsra_pkg::ST_IDLE);
    pwe = (st_r == hsra_pkg::ST_PWR) ||
          (wiping && clr_r < hsra_pkg::CurW'(hsra_pkg::PrimarySlots));
    owe = (st_r == hsra_pkg::ST_OWR) ||
          (wiping && clr_r < hsra_pkg::CurW'(hsra_pkg::OverflowSlots));
    pwaddr = wiping ? PW'(clr_r) : pidx_r;
    owaddr = wiping ? OW'(clr_r) : oidx_r;
    wdata = wiping ? '0 : {1'b1, w_r.key, sumsat};
    praddr = (st_r == hsra_pkg::ST_DSCAN) ? cur_pi : pidx_r;
    oraddr = (st_r == hsra_pkg::ST_DSCAN) ? cur_oi : oidx_r;
    load_out = (st_r == hsra_pkg::ST_EMIT) && (!ov_r || out_ready);
  end

  // Probe, drain and clear bookkeeping; the clearing pass also runs after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hsra_pkg::ST_WIPE;
      cnt_r <= '0;
      failed_r <= 1'b0;
      cur_r <= '0;
      clr_r <= '0;
      wipe_end_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        hsra_pkg::ST_IDLE: if (q_valid) begin
          w_r <= q_data;
          pidx_r <= q_data.key[PW-1:0];
          pcnt_r <= '0;
          osz_r <= (ovf_size > 11'(hsra_pkg::OverflowSlots))
                   ? (OW+1)'(hsra_pkg::OverflowSlots) : (OW+1)'(ovf_size);
          omask_r <= (ovf_size > 11'(hsra_pkg::OverflowSlots))
                     ? OW'(hsra_pkg::OverflowSlots - 1) : OW'(ovf_size - 11'd1);
        end
        hsra_pkg::ST_PCHK: begin
          hit_new_r <= !pocc;
          if (!(!pocc || pk == w_r.key)) begin
            pidx_r <= pidx_r + 1'b1;
            pcnt_r <= pcnt_r + 1'b1;
          end
          oidx_r <= OW'(w_r.key) & omask_r;
          ocnt_r <= '0;
          if (st_nxt == hsra_pkg::ST_EMIT) begin
            failed_r <= 1'b1;
            cnt_r <= cnt_inc;
            rs_r <= '{KIND_LOST_F, 11'd0, 24'(w_r.key), 32'sd0, cnt_inc, 1'b1, 1'b0};
          end
        end
        hsra_pkg::ST_OCHK: begin
          hit_new_r <= !oocc;
          if (!(!oocc || ok == w_r.key)) begin
            oidx_r <= (oidx_r + 1'b1) & omask_r;
            ocnt_r <= ocnt_r + 1'b1;
          end
          if (st_nxt == hsra_pkg::ST_EMIT) begin
            failed_r <= 1'b1;
            cnt_r <= cnt_inc;
            rs_r <= '{KIND_LOST_F, 11'd0, 24'(w_r.key), 32'sd0, cnt_inc, 1'b1, 1'b0};
          end
        end
        hsra_pkg::ST_PWR, hsra_pkg::ST_OWR: begin
          logic [15:0] c;
          c = hit_new_r ? cnt_inc : cnt_r;
          cnt_r <= c;
          rs_r <= '{hit_new_r ? KIND_NEW_F : KIND_ACC_F,
                    (st_r == hsra_pkg::ST_PWR) ? 11'(pidx_r)
                      : 11'(hsra_pkg::PrimarySlots) + 11'(oidx_r),
                    24'(w_r.key), sumsat, c, failed_r, 1'b0};
        end
        hsra_pkg::ST_DCHK: begin
          cur_r <= cur_r + 1'b1;
          if (cur_occ) begin
            rs_r <= '{KIND_DRAIN_F, 11'(cur_r), 24'(cur_p ? pk : ok),
                      cur_p ? pv : ov, cnt_r, failed_r, 1'b0};
          end
        end
        hsra_pkg::ST_CLR: begin
          rs_r <= '{KIND_END_F, 11'd0, 24'd0, 32'sd0, cnt_r, failed_r, 1'b1};
          cnt_r <= '0;
          failed_r <= 1'b0;
          cur_r <= '0;
          clr_r <= '0;
          wipe_end_r <= 1'b1;
        end
        hsra_pkg::ST_WIPE: clr_r <= clr_r + 1'b1;
        default: ;
      endcase
    end
  end

  // Output register: holds one result while the next item is worked on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load_out) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
    if (load_out) res_r <= rs_r;
  end

  assign out_valid = ov_r;
  assign out_data = res_r;

  `HSRA_ASSERT_IMP(a_last_end, clk, rst_n, out_valid && out_data.last,
    out_data.result_kind == KIND_END_F)
  `HSRA_ASSERT_NEXT(a_clr_empties, clk, rst_n, st_r == hsra_pkg::ST_CLR,
    cnt_r == '0 && !failed_r)
  `HSRA_ASSERT_IMP(a_lost_fails, clk, rst_n,
    out_valid && out_data.result_kind == KIND_LOST_F, out_data.row_failed)
endmodule

[hw/rtl/hash_sparse_row_accumulator_top.sv]
// Hash sparse row accumulator: an insert whose first probe hits passes through multiply,
// queue, RAM read, compare, write and result register before its result is given, and
// holds the back end in its idle, read, compare, write and emit states; each further probe
// adds one RAM read and one compare, so a long collision chain sets the time. A drain
// spends a scan state and a check state on each slot it scans; the end-of-row drain scans
// to the end of both tables and then clears the occupied marks in a pass over both tables,
// one entry of each table per cycle. The same pass runs after reset before the first
// item is taken. The front multiplies and queues up to two items, taking no new
// item while its multiply register is full, so input acceptance continues while the
// back probes. Top level; depends on hsra_pkg, hsra_front and hsra_back.
module hash_sparse_row_accumulator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsra_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsra_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [10:0]         cfg_data
);
  logic [10:0] ovf_size_r;
  logic skip_r;
  logic q_valid, q_ready;
  hsra_pkg::work_t q_data;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_size_r <= '0;
      skip_r <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        hsra_pkg::CFG_OVF_SIZE: ovf_size_r <= cfg_data;
        hsra_pkg::CFG_SKIP: skip_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hsra_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

  hsra_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
    .ovf_size(ovf_size_r), .skip_cfg(skip_r), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data));
endmodule
